>>> sv/ugec_pkg.sv
`default_nettype none
package ugec_pkg;

    // Field widths fixed by the stream format
    localparam int VERT_W   = 6;
    localparam int VSPACE   = 64;   // vertices a 6-bit field can name
    localparam int CNT_W    = 7;
    localparam int FLOW_W   = 10;
    localparam int STAT_W   = 2;
    localparam int RES_W    = 2;

    localparam logic [FLOW_W-1:0] FLOW_CAP = 10'd1000;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_PAIR   = 2'd1,
        ACT_GLOBAL = 2'd2,
        ACT_NONE   = 2'd3
    } act_t;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic              load;
        logic              status_we;
        logic [STAT_W-1:0] status_val;
        logic              global_init;
        logic              pair_init;
        logic              total_cap;
        logic              add_rd_u;
        logic              add1;
        logic              add2;
        logic              aug_start;
        logic              aug_head;
        logic              fetch_rd;
        logic              fetch_pop;
        logic              pop;
        logic              adv_link;
        logic              eval_found;
        logic              eval_push;
        logic              eval_next;
        logic              head_load;
        logic              upd_rd;
        logic              upd_e;
        logic              upd_ew;
        logic              upd_pw;
        logic              restore;
        logic              pair_next;
        logic              emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        act_t act;
        logic uv_ok;
        logic full;
        logic cnt_over;
        logic same_uv;
        logic cnt_lt2;
        logic out_free;
        logic top_valid;
        logic d_zero;
        logic hit;
        logic sink;
        logic can_push;
        logic k_last;
        logic total_sat;
        logic restore_done;
        logic pair_more;
    } sts_t;

endpackage
`default_nettype wire

>>> sv/ugec_ram.sv
`default_nettype none
module ugec_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> sv/ugec_ctrl.sv
`default_nettype none
module ugec_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire ugec_pkg::sts_t sts,
    output ugec_pkg::cmd_t     cmd
);
    import ugec_pkg::*;

    typedef enum logic [18:0] {
        IDLE      = 19'b0000000000000000001,
        DISPATCH  = 19'b0000000000000000010,
        ADD1      = 19'b0000000000000000100,
        ADD2      = 19'b0000000000000001000,
        AUG_START = 19'b0000000000000010000,
        AUG_HEAD  = 19'b0000000000000100000,
        FETCH     = 19'b0000000000001000000,
        EVAL      = 19'b0000000000010000000,
        POP       = 19'b0000000000100000000,
        ADV_LINK  = 19'b0000000001000000000,
        HEAD      = 19'b0000000010000000000,
        UPD_RD    = 19'b0000000100000000000,
        UPD_E     = 19'b0000001000000000000,
        UPD_EW    = 19'b0000010000000000000,
        UPD_PW    = 19'b0000100000000000000,
        RESTORE   = 19'b0001000000000000000,
        PAIR_DONE = 19'b0010000000000000000,
        EMIT      = 19'b0100000000000000000,
        SPARE     = 19'b1000000000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == IDLE) && sts.out_free;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            IDLE: begin
                if (s_tvalid && sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = DISPATCH;
                end
            end
            DISPATCH: begin
                state_next = EMIT;
                case (sts.act)
                    ACT_ADD: begin
                        if (!sts.uv_ok) begin
                            cmd.status_we  = 1'b1;
                            cmd.status_val = ST_RANGE;
                        end else if (sts.full) begin
                            cmd.status_we  = 1'b1;
                            cmd.status_val = ST_FULL;
                        end else begin
                            cmd.add_rd_u = 1'b1;
                            state_next   = ADD1;
                        end
                    end
                    ACT_PAIR: begin
                        if (!sts.uv_ok) begin
                            cmd.status_we  = 1'b1;
                            cmd.status_val = ST_RANGE;
                        end else if (sts.same_uv) begin
                            cmd.total_cap = 1'b1;
                        end else begin
                            cmd.pair_init = 1'b1;
                            state_next    = AUG_START;
                        end
                    end
                    ACT_GLOBAL: begin
                        if (sts.cnt_over) begin
                            cmd.status_we  = 1'b1;
                            cmd.status_val = ST_RANGE;
                        end else begin
                            cmd.global_init = 1'b1;
                            cmd.pair_init   = 1'b1;
                            if (!sts.cnt_lt2) begin
                                state_next = AUG_START;
                            end
                        end
                    end
                    default: begin
                        state_next = EMIT;
                    end
                endcase
            end
            ADD1: begin
                cmd.add1   = 1'b1;
                state_next = ADD2;
            end
            ADD2: begin
                cmd.add2   = 1'b1;
                state_next = EMIT;
            end
            AUG_START: begin
                cmd.aug_start = 1'b1;
                state_next    = AUG_HEAD;
            end
            AUG_HEAD: begin
                cmd.aug_head = 1'b1;
                state_next   = FETCH;
            end
            FETCH: begin
                if (sts.top_valid) begin
                    cmd.fetch_rd = 1'b1;
                    state_next   = EVAL;
                end else if (sts.d_zero) begin
                    state_next = RESTORE;
                end else begin
                    cmd.fetch_pop = 1'b1;
                    state_next    = POP;
                end
            end
            POP: begin
                cmd.pop    = 1'b1;
                state_next = ADV_LINK;
            end
            ADV_LINK: begin
                cmd.adv_link = 1'b1;
                state_next   = FETCH;
            end
            EVAL: begin
                if (sts.hit && sts.sink) begin
                    cmd.eval_found = 1'b1;
                    state_next     = UPD_RD;
                end else if (sts.hit && sts.can_push) begin
                    cmd.eval_push = 1'b1;
                    state_next    = HEAD;
                end else begin
                    cmd.eval_next = 1'b1;
                    state_next    = FETCH;
                end
            end
            HEAD: begin
                cmd.head_load = 1'b1;
                state_next    = FETCH;
            end
            UPD_RD: begin
                cmd.upd_rd = 1'b1;
                state_next = UPD_E;
            end
            UPD_E: begin
                cmd.upd_e  = 1'b1;
                state_next = UPD_EW;
            end
            UPD_EW: begin
                cmd.upd_ew = 1'b1;
                state_next = UPD_PW;
            end
            UPD_PW: begin
                cmd.upd_pw = 1'b1;
                if (!sts.k_last) begin
                    state_next = UPD_RD;
                end else if (sts.total_sat) begin
                    state_next = RESTORE;
                end else begin
                    state_next = AUG_START;
                end
            end
            RESTORE: begin
                cmd.restore = 1'b1;
                if (sts.restore_done) begin
                    state_next = PAIR_DONE;
                end
            end
            PAIR_DONE: begin
                state_next = EMIT;
                if (sts.act == ACT_GLOBAL) begin
                    cmd.pair_next = 1'b1;
                    if (sts.pair_more) begin
                        cmd.pair_init = 1'b1;
                        state_next    = AUG_START;
                    end
                end
            end
            EMIT: begin
                cmd.emit   = 1'b1;
                state_next = IDLE;
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> sv/ugec_dp.sv
`default_nettype none
module ugec_dp #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_ARCS     = 256
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [1:0]                 s_tuser,
    input  wire logic [15:0]                s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [15:0]                     m_tdata,
    output logic [1:0]                      m_tuser,
    input  wire logic                       cfg_we,
    input  wire logic [ugec_pkg::CNT_W-1:0] cfg_wdata,
    input  wire ugec_pkg::cmd_t             cmd,
    output ugec_pkg::sts_t                  sts
);
    import ugec_pkg::*;

    localparam int AW = $clog2(MAX_ARCS + 1);   // arc index incl. null marker
    localparam int IW = $clog2(MAX_ARCS);       // arc memory address
    localparam int DW = $clog2(MAX_VERTICES);   // path depth
    localparam int HW = $clog2(VSPACE);
    localparam logic [AW-1:0] ARC_NULL = AW'(MAX_ARCS);

    // request and config
    act_t              act_reg;
    logic [VERT_W-1:0] u_reg, v_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [STAT_W-1:0] stat_reg;

    // graph state
    logic [AW-1:0]     arc_total_reg;
    logic [VSPACE-1:0] hv_reg;
    logic              hv_q;
    logic [VSPACE-1:0] seen_reg;

    // search state
    logic [DW-1:0]     d_reg, k_reg;
    logic [AW-1:0]     top_reg, e_reg;
    logic [RES_W-1:0]  mintop_reg, m_reg;
    logic [FLOW_W-1:0] total_reg, best_reg;
    logic [CNT_W-1:0]  s_reg, t_reg;
    logic [AW-1:0]     sweep_reg;

    // output register
    logic              mv_reg;
    logic [FLOW_W-1:0] mflow_reg;
    logic [STAT_W-1:0] mstat_reg;

    // memory ports
    logic [HW-1:0]            head_raddr, head_waddr;
    logic [AW-1:0]            head_rdata, head_wdata;
    logic                     head_we;
    logic [IW-1:0]            arc_raddr, arc_waddr;
    logic [VERT_W+AW-1:0]     arc_rdata, arc_wdata;
    logic                     arc_we;
    logic [IW-1:0]            res_raddr, res_waddr;
    logic [RES_W-1:0]         res_rdata, res_wdata;
    logic                     res_we;
    logic [DW-1:0]            stk_raddr;
    logic [AW+RES_W-1:0]      stk_rdata;

    logic [VERT_W-1:0] src, snk, to;
    logic [AW-1:0]     link, head_val, stk_arc, f_idx, r_idx, p_idx, e_sel, add2_link;
    logic [RES_W-1:0]  stk_min, m_val;
    logic              p_ok, sweep_act;

    ugec_ram #(.W(AW), .D(VSPACE)) u_head (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );
    ugec_ram #(.W(VERT_W + AW), .D(MAX_ARCS)) u_arc (
        .aclk(aclk), .we(arc_we), .waddr(arc_waddr), .wdata(arc_wdata),
        .raddr(arc_raddr), .rdata(arc_rdata)
    );
    ugec_ram #(.W(RES_W), .D(MAX_ARCS)) u_res (
        .aclk(aclk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
        .raddr(res_raddr), .rdata(res_rdata)
    );
    ugec_ram #(.W(AW + RES_W), .D(MAX_VERTICES)) u_stk (
        .aclk(aclk), .we(cmd.eval_push), .waddr(d_reg), .wdata({top_reg, mintop_reg}),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    assign src      = (act_reg == ACT_PAIR) ? u_reg : s_reg[VERT_W-1:0];
    assign snk      = (act_reg == ACT_PAIR) ? v_reg : t_reg[VERT_W-1:0];
    assign to       = arc_rdata[VERT_W+AW-1:AW];
    assign link     = arc_rdata[AW-1:0];
    assign head_val = hv_q ? head_rdata : ARC_NULL;
    assign stk_arc  = stk_rdata[AW+RES_W-1:RES_W];
    assign stk_min  = stk_rdata[RES_W-1:0];
    assign f_idx    = arc_total_reg;
    assign r_idx    = arc_total_reg + AW'(1);
    assign p_idx    = e_reg ^ AW'(1);
    assign p_ok     = int'(p_idx) < MAX_ARCS;
    assign e_sel    = (k_reg < d_reg) ? stk_arc : top_reg;
    assign m_val    = (d_reg == '0 || res_rdata < mintop_reg) ? res_rdata : mintop_reg;
    assign sweep_act = sweep_reg < arc_total_reg;
    // a self loop sees its own forward arc at the head of the list
    assign add2_link = (u_reg == v_reg) ? f_idx : head_val;

    // read addresses
    always_comb begin
        head_raddr = to;
        if (cmd.add_rd_u) begin
            head_raddr = u_reg;
        end else if (cmd.add1) begin
            head_raddr = v_reg;
        end else if (cmd.aug_start) begin
            head_raddr = src;
        end
        arc_raddr = top_reg[IW-1:0];
        if (cmd.pop) begin
            arc_raddr = stk_arc[IW-1:0];
        end
        res_raddr = top_reg[IW-1:0];
        if (cmd.upd_e) begin
            res_raddr = e_sel[IW-1:0];
        end else if (cmd.upd_ew) begin
            res_raddr = p_idx[IW-1:0];
        end
        stk_raddr = k_reg;
        if (cmd.fetch_pop) begin
            stk_raddr = d_reg - DW'(1);
        end
    end

    // writes
    always_comb begin
        head_we    = cmd.add1 || cmd.add2;
        head_waddr = cmd.add1 ? u_reg : v_reg;
        head_wdata = cmd.add1 ? f_idx : r_idx;
        arc_we     = cmd.add1 || cmd.add2;
        arc_waddr  = cmd.add1 ? f_idx[IW-1:0] : r_idx[IW-1:0];
        arc_wdata  = cmd.add1 ? {v_reg, head_val} : {u_reg, add2_link};
        res_we     = 1'b0;
        res_waddr  = sweep_reg[IW-1:0];
        res_wdata  = RES_W'(1);
        if (cmd.add1 || cmd.add2) begin
            res_we    = 1'b1;
            res_waddr = arc_waddr;
        end else if (cmd.upd_ew) begin
            res_we    = 1'b1;
            res_waddr = e_reg[IW-1:0];
            res_wdata = res_rdata - m_reg;
        end else if (cmd.upd_pw) begin
            res_we    = p_ok;
            res_waddr = p_idx[IW-1:0];
            res_wdata = res_rdata + m_reg;
        end else if (cmd.restore) begin
            res_we = sweep_act;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            arc_total_reg <= '0;
            hv_reg        <= '0;
            mv_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                cnt_reg <= cfg_wdata;
            end
            if (cmd.add1) begin
                hv_reg[u_reg] <= 1'b1;
            end
            if (cmd.add2) begin
                hv_reg[v_reg]  <= 1'b1;
                arc_total_reg <= arc_total_reg + AW'(2);
            end
            if (cmd.emit) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hv_q <= hv_reg[head_raddr];
        if (cmd.load) begin
            act_reg  <= act_t'(s_tuser);
            u_reg    <= s_tdata[VERT_W-1:0];
            v_reg    <= s_tdata[2*VERT_W-1:VERT_W];
            stat_reg <= ST_OK;
        end
        if (cmd.status_we) begin
            stat_reg <= cmd.status_val;
        end
        if (cmd.global_init) begin
            s_reg    <= '0;
            t_reg    <= CNT_W'(1);
            best_reg <= FLOW_CAP;
        end
        if (cmd.pair_init) begin
            total_reg <= '0;
        end
        if (cmd.total_cap) begin
            total_reg <= FLOW_CAP;
        end
        if (cmd.aug_start) begin
            seen_reg      <= '0;
            seen_reg[src] <= 1'b1;
            d_reg         <= '0;
        end
        if (cmd.aug_head || cmd.head_load) begin
            top_reg <= head_val;
        end
        if (cmd.fetch_pop) begin
            d_reg <= d_reg - DW'(1);
        end
        if (cmd.pop) begin
            top_reg    <= stk_arc;
            mintop_reg <= stk_min;
        end
        if (cmd.adv_link || cmd.eval_next) begin
            top_reg <= link;
        end
        if (cmd.eval_push) begin
            seen_reg[to] <= 1'b1;
            d_reg        <= d_reg + DW'(1);
            mintop_reg   <= m_val;
        end
        if (cmd.eval_found) begin
            m_reg <= m_val;
            k_reg <= '0;
            if ({1'b0, total_reg} + (FLOW_W + 1)'(m_val) >= (FLOW_W + 1)'(FLOW_CAP)) begin
                total_reg <= FLOW_CAP;
            end else begin
                total_reg <= total_reg + FLOW_W'(m_val);
            end
        end
        if (cmd.upd_e) begin
            e_reg <= e_sel;
        end
        if (cmd.upd_pw) begin
            k_reg <= k_reg + DW'(1);
        end
        sweep_reg <= (cmd.restore && sweep_act) ? sweep_reg + AW'(1) : '0;
        if (cmd.pair_next) begin
            if (total_reg < best_reg) begin
                best_reg <= total_reg;
            end
            if (t_reg + CNT_W'(1) < cnt_reg) begin
                t_reg <= t_reg + CNT_W'(1);
            end else begin
                s_reg <= s_reg + CNT_W'(1);
                t_reg <= s_reg + CNT_W'(2);
            end
        end
        if (cmd.emit) begin
            mstat_reg <= stat_reg;
            if (stat_reg != ST_OK) begin
                mflow_reg <= '0;
            end else if (act_reg == ACT_PAIR) begin
                mflow_reg <= total_reg;
            end else if (act_reg == ACT_GLOBAL) begin
                mflow_reg <= best_reg;
            end else begin
                mflow_reg <= '0;
            end
        end
    end

    // status to controller
    always_comb begin
        sts.act          = act_reg;
        sts.uv_ok        = (CNT_W'(u_reg) < cnt_reg) && (int'(u_reg) < MAX_VERTICES)
                        && (CNT_W'(v_reg) < cnt_reg) && (int'(v_reg) < MAX_VERTICES);
        sts.full         = int'(arc_total_reg) + 2 > MAX_ARCS;
        sts.cnt_over     = int'(cnt_reg) > MAX_VERTICES;
        sts.same_uv      = u_reg == v_reg;
        sts.cnt_lt2      = cnt_reg < CNT_W'(2);
        sts.out_free     = !mv_reg || m_tready;
        sts.top_valid    = (int'(top_reg) < MAX_ARCS) && (top_reg < arc_total_reg);
        sts.d_zero       = d_reg == '0;
        sts.hit          = (int'(to) < MAX_VERTICES) && !seen_reg[to] && (res_rdata != '0);
        sts.sink         = to == snk;
        sts.can_push     = int'(d_reg) + 1 < MAX_VERTICES;
        sts.k_last       = k_reg == d_reg;
        sts.total_sat    = total_reg == FLOW_CAP;
        sts.restore_done = !sweep_act;
        sts.pair_more    = (t_reg + CNT_W'(1) < cnt_reg) || (s_reg + CNT_W'(2) < cnt_reg);
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {(16 - FLOW_W)'(0), mflow_reg};
    assign m_tuser  = mstat_reg;
endmodule
`default_nettype wire

>>> sv/unit_graph_edge_connectivity.sv
// Sequence: add edge goes DISPATCH, ADD1, ADD2, EMIT; rejected, ignored or same-vertex requests go
//   from DISPATCH to EMIT. Queries: each augment runs AUG_START, AUG_HEAD, scans arcs in FETCH/EVAL,
//   descends via HEAD, backtracks via POP/ADV_LINK and updates residuals in UPD_RD to UPD_PW per path
//   arc; each pair then runs a restore sweep over the arcs and PAIR_DONE, and a global query repeats
//   this for every s<t. Throughput: one request at a time, taken once the result register is free
//   or being taken. Reset: sync active-low aresetn clears FSM and counters.
`default_nettype none
module unit_graph_edge_connectivity #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_ARCS     = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [5:0] first_vertex, [11:6] second_vertex
    input  wire logic [1:0]  s_tuser,    // [1:0] action
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [9:0] flow_value
    output logic [1:0]       m_tuser,    // [1:0] status
    // vertex_count register
    input  wire logic        cfg_we,
    input  wire logic [6:0]  cfg_wdata
);
    import ugec_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer: request dispatch, edge insert, DFS walk, path update, restore sweep
    ugec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Arc/head/residual/path memories, counters and the result register
    ugec_dp #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_ARCS    (MAX_ARCS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .cmd      (cmd),
        .sts      (sts)
    );
endmodule
`default_nettype wire

>>> sv/ugec_checker.sv
`default_nettype none
module ugec_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    // result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped before taken");

    // one request in flight: busy right after accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // error results carry no flow
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != 2'd0 |-> m_tdata[9:0] == 10'd0)
        else $error("flow on error result");

    // flow saturates at cap, status code in range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[9:0] <= 10'd1000 && m_tuser != 2'd3 && m_tdata[15:10] == 6'd0)
        else $error("result out of range");
endmodule

bind unit_graph_edge_connectivity ugec_checker u_ugec_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ugec_pkg::*;

    // Single-item stalls never come close to this. Dense global queries are
    // kept to small vertex counts so that they stay well below it.
    localparam int STALL_LIMIT = 8000000;
    localparam int NARC        = 256;
    localparam int NVERT       = 64;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;

    unit_graph_edge_connectivity i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Graph shadow: arc store, adjacency heads, residuals, DFS stacks
    // ---------------------------------------------------------------
    int       arc_to   [NARC];
    int       arc_next [NARC];
    bit [1:0] arc_cap  [NARC];
    int       adj_head [NVERT];
    bit       visited  [NVERT];
    int       dfs_arc  [NVERT];
    int       dfs_min  [NVERT];
    int       arcs_used;
    int       num_verts;

    typedef struct {
        logic [FLOW_W-1:0] flow;
        logic [STAT_W-1:0] stat;
    } answer_t;

    answer_t pending_results[$];
    int      errors;
    int      n_requests;
    int      n_results;
    int      n_by_status[4];

    function automatic bit vert_valid(int v);
        return v < num_verts && v < NVERT;
    endfunction

    function automatic int follow(int a);
        return (a < NARC) ? arc_next[a] : NARC;
    endfunction

    // one DFS augmenting path; returns pushed amount
    function automatic int augment(int src, int snk);
        int d;
        int a;
        int to;
        int m;
        int e;
        d = 0;
        foreach (visited[i]) visited[i] = 1'b0;
        visited[src] = 1'b1;
        dfs_min[0] = 1000;
        dfs_arc[0] = adj_head[src];
        while (1) begin
            a = dfs_arc[d];
            if (a >= NARC || a >= arcs_used) begin
                if (d == 0) return 0;
                d--;
                dfs_arc[d] = follow(dfs_arc[d]);
                continue;
            end
            to = arc_to[a];
            if (to < NVERT && !visited[to] && arc_cap[a] > 0) begin
                m = dfs_min[d];
                if (arc_cap[a] < m) m = arc_cap[a];
                if (to == snk) begin
                    for (int k = 0; k <= d; k++) begin
                        e = dfs_arc[k];
                        arc_cap[e]     = 2'(arc_cap[e] - m);
                        arc_cap[e ^ 1] = 2'(arc_cap[e ^ 1] + m);
                    end
                    return m;
                end
                if (d + 1 < NVERT) begin
                    visited[to] = 1'b1;
                    d++;
                    dfs_min[d] = m;
                    dfs_arc[d] = adj_head[to];
                    continue;
                end
            end
            dfs_arc[d] = follow(a);
        end
    endfunction

    function automatic int max_flow(int src, int snk);
        int total;
        int got;
        total = 0;
        if (src == snk) return 1000;
        while (1) begin
            got = augment(src, snk);
            if (got == 0) break;
            total += got;
            if (total >= 1000) begin
                total = 1000;
                break;
            end
        end
        for (int i = 0; i < arcs_used; i++) arc_cap[i] = 2'd1;
        return total;
    endfunction

    function automatic answer_t graph_predict(act_t act, int u, int v);
        answer_t r;
        int f;
        int best;
        r.flow = '0;
        r.stat = ST_OK;
        case (act)
            ACT_ADD: begin
                if (!vert_valid(u) || !vert_valid(v)) begin
                    r.stat = ST_RANGE;
                end else if (arcs_used + 2 > NARC) begin
                    r.stat = ST_FULL;
                end else begin
                    arc_to[arcs_used]       = v;
                    arc_next[arcs_used]     = adj_head[u];
                    adj_head[u]             = arcs_used;
                    arc_cap[arcs_used]      = 2'd1;
                    arc_to[arcs_used + 1]   = u;
                    arc_next[arcs_used + 1] = adj_head[v];
                    adj_head[v]             = arcs_used + 1;
                    arc_cap[arcs_used + 1]  = 2'd1;
                    arcs_used += 2;
                end
            end
            ACT_PAIR: begin
                if (!vert_valid(u) || !vert_valid(v)) r.stat = ST_RANGE;
                else r.flow = FLOW_W'(max_flow(u, v));
            end
            ACT_GLOBAL: begin
                if (num_verts > NVERT) begin
                    r.stat = ST_RANGE;
                end else begin
                    best = 1000;
                    for (int s = 0; s < num_verts; s++)
                        for (int t = s + 1; t < num_verts; t++) begin
                            f = max_flow(s, t);
                            if (f < best) best = f;
                        end
                    r.flow = FLOW_W'(best);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result side: backpressure, long hold-off, checker, watchdog
    // ---------------------------------------------------------------
    int recv_stall_pct;
    int send_gap_pct;
    bit hold_request;
    int hold_left;

    initial begin
        m_tready  = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (hold_request) begin
                // long hold so the block fills and stalls its request side
                hold_request = 1'b0;
                hold_left    = 300;
                m_tready     = 1'b0;
            end else begin
                m_tready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            n_by_status[m_tuser]++;
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding: flow %0d status %0d",
                       m_tdata[9:0], m_tuser);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[9:0] !== want.flow) begin
                    $error("flow_value: expected %0d, got %0d", want.flow, m_tdata[9:0]);
                    errors++;
                end
                if (m_tuser !== want.stat) begin
                    $error("status: expected %0d, got %0d", want.stat, m_tuser);
                    errors++;
                end
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------

    // called at a falling edge; returns at a falling edge
    task automatic send_request(act_t act, int u, int v, bit typed, int t_flow, int t_stat);
        answer_t r;
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {4'b0, 6'(v), 6'(u)};
        do @(posedge aclk); while (!s_tready);
        r = graph_predict(act, u, v);
        if (typed) begin
            r.flow = FLOW_W'(t_flow);
            r.stat = STAT_W'(t_stat);
        end
        pending_results.push_back(r);
        n_requests++;
        @(negedge aclk);
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = 16'($urandom);
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // only when idle
    task automatic write_count(int val);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = 7'(val);
        @(negedge aclk);
        cfg_we    = 1'b0;
        num_verts = val;
    endtask

    // directed script; wr rows set vertex_count to a
    typedef struct {
        bit   wr;
        act_t act;
        int   a;
        int   b;
        bit   typed;
        int   flow;
        int   stat;
    } step_t;

    step_t script[] = '{
        '{0, ACT_GLOBAL, 0,  0,  1, 1000, 0},  // count 0 after reset
        '{0, ACT_ADD,    0,  0,  1, 0,    2},  // no vertex in use yet
        '{1, ACT_NONE,   1,  0,  0, 0,    0},
        '{0, ACT_GLOBAL, 0,  0,  1, 1000, 0},  // single vertex
        '{1, ACT_NONE,   64, 0,  0, 0,    0},
        '{0, ACT_ADD,    0,  63, 1, 0,    0},
        '{0, ACT_ADD,    63, 1,  1, 0,    0},
        '{0, ACT_ADD,    5,  5,  1, 0,    0},  // self loop is stored
        '{0, ACT_ADD,    0,  1,  1, 0,    0},
        '{0, ACT_PAIR,   0,  1,  0, 0,    0},
        '{0, ACT_PAIR,   63, 63, 1, 1000, 0},  // source equals sink
        '{0, ACT_PAIR,   1,  0,  0, 0,    0},
        '{0, ACT_PAIR,   2,  3,  1, 0,    0},  // disconnected
        '{0, ACT_GLOBAL, 0,  0,  0, 0,    0},  // all 2016 pairs, few arcs
        '{1, ACT_NONE,   127,0,  0, 0,    0},
        '{0, ACT_GLOBAL, 0,  0,  1, 0,    2},  // count beyond vertex space
        '{0, ACT_PAIR,   0,  63, 0, 0,    0},
        '{0, ACT_ADD,    10, 11, 1, 0,    0},
        '{1, ACT_NONE,   3,  0,  0, 0,    0},
        '{0, ACT_PAIR,   0,  63, 1, 0,    2},  // sink out of range
        '{0, ACT_ADD,    3,  0,  1, 0,    2},
        '{0, ACT_PAIR,   0,  1,  0, 0,    0},  // path through vertex 63 above count
        '{0, ACT_GLOBAL, 0,  0,  0, 0,    0},
        '{0, ACT_NONE,   63, 63, 1, 0,    0}    // unused action
    };

    function automatic int pick_vertex();
        if (num_verts == 0 || $urandom_range(9) == 0) return $urandom_range(63);
        return $urandom_range((num_verts > NVERT ? NVERT : num_verts) - 1);
    endfunction

    task automatic random_burst(int n_items, bit press);
        int   roll;
        act_t act;
        bit   glob_ok;
        // all-pairs search is costly on a dense graph: keep it to tiny counts
        glob_ok = (num_verts <= 5) || (num_verts > NVERT);
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (roll < 55)                act = ACT_ADD;
            else if (roll < 95)           act = ACT_PAIR;
            else if (roll < 97 && glob_ok) act = ACT_GLOBAL;
            else if (roll < 97)           act = ACT_PAIR;
            else                          act = ACT_NONE;
            if (press && i == n_items / 3) hold_request = 1'b1;
            if (press && i == 2 * n_items / 3) drain();
            send_request(act, pick_vertex(), pick_vertex(), 0, 0, 0);
        end
    endtask

    int counts[] = '{64, 4, 17, 2, 127, 5, 0, 64};

    initial begin
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        errors         = 0;
        n_requests     = 0;
        n_results      = 0;
        hold_request   = 1'b0;
        recv_stall_pct = 0;
        send_gap_pct   = 0;
        foreach (n_by_status[i]) n_by_status[i] = 0;
        foreach (adj_head[i]) adj_head[i] = NARC;
        foreach (arc_cap[i]) arc_cap[i] = 2'd0;
        arcs_used = 0;
        num_verts = 0;

        aresetn = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed part, light receiver stalls
        recv_stall_pct = 20;
        send_gap_pct   = 10;
        foreach (script[i]) begin
            if (script[i].wr)
                write_count(script[i].a);
            else
                send_request(script[i].act, script[i].a, script[i].b,
                             script[i].typed, script[i].flow, script[i].stat);
        end

        // random part: three idle profiles, each through several counts
        for (int ph = 0; ph < 3; ph++) begin
            send_gap_pct   = (ph == 0) ? 17 : (ph == 1) ? 49 : 0;
            recv_stall_pct = (ph == 0) ? 49 : (ph == 1) ? 17 : 0;
            foreach (counts[c]) begin
                write_count(counts[c]);
                random_burst(59, ph == 2 && c == 0);
            end
        end

        drain();
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("covered %0d requests, %0d results (ok %0d, full %0d, range %0d)",
                 n_requests, n_results, n_by_status[0], n_by_status[1], n_by_status[2]);
        $display("arc table ended with %0d of %0d arcs in use", arcs_used, NARC);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
